[design/vcds_pkg.sv]
package vcds_pkg;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

  // Motion phase, as presented on the phase output
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_DECAY = 2'd2
  } phase_e;

  // Item kinds
  localparam logic MODE_CMD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Command codes
  localparam logic [7:0] CMD_LIN_UP   = 8'd1;
  localparam logic [7:0] CMD_LIN_DOWN = 8'd2;
  localparam logic [7:0] CMD_ANG_DOWN = 8'd3;
  localparam logic [7:0] CMD_ANG_UP   = 8'd4;
  localparam logic [7:0] CMD_CLEAR    = 8'd5;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIN_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_TICKS = 2'd3;

  // Register widths and reset values
  localparam int unsigned STEP_W = 10;
  localparam int unsigned DUR_W  = 16;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [STEP_W-1:0] LIN_STEP_RST    = 10'd10;
  localparam logic [STEP_W-1:0] ANG_STEP_RST    = 10'd100;
  localparam logic [DUR_W-1:0]  WAIT_TICKS_RST  = 16'd300;
  localparam logic [DUR_W-1:0]  DECAY_TICKS_RST = 16'd1000;

endpackage

[design/velocity_command_decay_shaper_unit.sv]
// Velocity command shaper with angular decay.
//
// Input channel (in_valid_i / in_stall_o): one item per transfer, either a
// command (mode_i = 0, code on command_code_i) or a 1 ms tick (mode_i = 1).
// Output channel (out_valid_o / out_stall_i): exactly one result per input
// item, in order: linear and angular speed, invalid flag and phase.
// Configuration: cfg_we_i writes cfg_wdata_i into the register selected by
// cfg_index_i (linear step, angular step, wait ticks, decay ticks); write only
// while no item is in flight.
//
// Commands and ticks that need no ramp value go from the input transfer
// through ST_OUT into the output register; when the ramp value is computed,
// the item first passes ST_MUL (one multiply step) and ST_DIV, a restoring
// divider retiring one quotient bit per cycle, before ST_OUT.
// in_stall_o is high while an item is in flight, so a new item is taken only
// after the last one has left the sequencer.
// The result sits in an output register, so the next item is taken while a
// stalled result waits. A finished result that finds the output register
// still stalled waits in the sequencer until it drains.
// Reset clears speeds, phase and tick count and loads the register defaults.
module velocity_command_decay_shaper_unit
  import vcds_pkg::*;
#(
  parameter int unsigned SPEED_WIDTH = 16,
  parameter int unsigned TICK_WIDTH  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata_i,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [7:0]                    command_code_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SPEED_WIDTH-1:0] linear_speed_o,
  output logic signed [SPEED_WIDTH-1:0] angular_speed_o,
  output logic                          invalid_command_o,
  output logic [1:0]                    phase_o
);

  localparam int unsigned SW    = SPEED_WIDTH;
  localparam int unsigned TW    = TICK_WIDTH;
  // sum of a speed and a step, with headroom for the clamp
  localparam int unsigned SUM_W = ((SW > STEP_W + 1) ? SW : (STEP_W + 1)) + 1;
  // tick count against a 16-bit duration
  localparam int unsigned CMP_W = (TW > DUR_W) ? TW : DUR_W;
  // product of a magnitude and the ticks left
  localparam int unsigned PW    = SW - 1 + DUR_W;
  localparam int unsigned CNT_W = $clog2(SW - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SW - 2);

  localparam logic signed [SUM_W-1:0] LIM =
    {{(SUM_W - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] NLIM = -LIM;

  function automatic logic [SW-1:0] clamp_sum(input logic signed [SUM_W-1:0] v);
    logic [SW-1:0] r;
    if (v > LIM) begin
      r = LIM[SW-1:0];
    end else if (v < NLIM) begin
      r = NLIM[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [STEP_W-1:0] lin_step_q, ang_step_q;
  logic [DUR_W-1:0]  wait_ticks_q, decay_ticks_q;

  // architectural state
  logic signed [SW-1:0] lin_q, lin_d;
  logic signed [SW-1:0] ang_q, ang_d;
  logic signed [SW-1:0] dstart_q, dstart_d;
  phase_e               phase_q, phase_d;
  logic [TW-1:0]        tick_q, tick_d;
  logic                 inv_q, inv_d;

  // sequencer and divider
  state_e               state_q, state_d;
  logic [DUR_W-1:0]     rem_q, rem_d;
  logic [SW-2:0]        low_q, low_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic signed [SW-1:0] out_lin_q, out_lin_d;
  logic signed [SW-1:0] out_ang_q, out_ang_d;
  logic                 out_inv_q, out_inv_d;
  phase_e               out_phase_q, out_phase_d;

  logic in_xfer, need_div, out_free;
  logic [TW-1:0]        tick_inc;
  logic [CMP_W-1:0]     tick_inc_ext, tick_ext, wait_ext, decay_ext;
  logic signed [SUM_W-1:0] lin_ext, ang_ext, lin_step_ext, ang_step_ext;
  logic signed [SW-1:0] dstart_neg;
  logic [SW-2:0]        mag;
  logic [DUR_W-1:0]     left;
  logic [PW-1:0]        prod;
  logic [DUR_W:0]       trial, diff;
  logic                 ge;
  logic [SW-2:0]        quot;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign tick_inc     = (&tick_q) ? tick_q : tick_q + 1'b1;
  assign tick_inc_ext = CMP_W'(tick_inc);
  assign tick_ext     = CMP_W'(tick_q);
  assign wait_ext     = CMP_W'(wait_ticks_q);
  assign decay_ext    = CMP_W'(decay_ticks_q);

  assign lin_ext      = SUM_W'(lin_q);
  assign ang_ext      = SUM_W'(ang_q);
  assign lin_step_ext = SUM_W'(lin_step_q);
  assign ang_step_ext = SUM_W'(ang_step_q);

  // multiply step: |decay_start| * ticks left (elapsed < decay here)
  assign dstart_neg = -dstart_q;
  assign mag        = dstart_q[SW-1] ? dstart_neg[SW-2:0] : dstart_q[SW-2:0];
  assign left       = decay_ticks_q - tick_ext[DUR_W-1:0];
  assign prod       = PW'(mag) * PW'(left);

  // one restoring divide step
  assign trial = {rem_q, low_q[SW-2]};
  assign diff  = trial - {1'b0, decay_ticks_q};
  assign ge    = (trial >= {1'b0, decay_ticks_q});
  assign quot  = {low_q[SW-3:0], ge};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = need_div ? ST_MUL : ST_OUT;
        end
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == CNT_LAST) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    lin_d       = lin_q;
    ang_d       = ang_q;
    dstart_d    = dstart_q;
    phase_d     = phase_q;
    tick_d      = tick_q;
    inv_d       = inv_q;
    rem_d       = rem_q;
    low_d       = low_q;
    cnt_d       = cnt_q;
    need_div    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_lin_d   = out_lin_q;
    out_ang_d   = out_ang_q;
    out_inv_d   = out_inv_q;
    out_phase_d = out_phase_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          inv_d = 1'b0;
          if (mode_i == MODE_CMD) begin
            case (command_code_i)
              CMD_LIN_UP:   lin_d = clamp_sum(lin_ext + lin_step_ext);
              CMD_LIN_DOWN: lin_d = clamp_sum(lin_ext - lin_step_ext);
              CMD_ANG_DOWN: begin
                ang_d   = clamp_sum(ang_ext - ang_step_ext);
                phase_d = PH_WAIT;
                tick_d  = '0;
              end
              CMD_ANG_UP: begin
                ang_d   = clamp_sum(ang_ext + ang_step_ext);
                phase_d = PH_WAIT;
                tick_d  = '0;
              end
              CMD_CLEAR: begin
                lin_d    = '0;
                ang_d    = '0;
                dstart_d = '0;
                tick_d   = '0;
                phase_d  = PH_IDLE;
              end
              default: inv_d = 1'b1;
            endcase
          end else if (phase_q == PH_WAIT) begin
            if (tick_inc_ext >= wait_ext) begin
              // wait over: ramp starts at elapsed zero
              dstart_d = ang_q;
              tick_d   = '0;
              if (decay_ticks_q == '0) begin
                ang_d   = '0;
                phase_d = PH_IDLE;
              end else begin
                phase_d  = PH_DECAY;
                need_div = 1'b1;
              end
            end else begin
              tick_d = tick_inc;
            end
          end else if (phase_q == PH_DECAY) begin
            tick_d = tick_inc;
            if (tick_inc_ext >= decay_ext) begin
              ang_d   = '0;
              phase_d = PH_IDLE;
            end else begin
              need_div = 1'b1;
            end
          end
        end
      end
      ST_MUL: begin
        rem_d = prod[PW-1:SW-1];
        low_d = prod[SW-2:0];
        cnt_d = '0;
      end
      ST_DIV: begin
        rem_d = ge ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
        low_d = quot;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          ang_d = dstart_q[SW-1] ? -SW'(quot) : SW'(quot);
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_lin_d   = lin_q;
          out_ang_d   = ang_q;
          out_inv_d   = inv_q;
          out_phase_d = phase_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lin_q       <= '0;
      ang_q       <= '0;
      dstart_q    <= '0;
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      inv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lin_q       <= lin_d;
      ang_q       <= ang_d;
      dstart_q    <= dstart_d;
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      inv_q       <= inv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // divider and output payload, no reset
  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    low_q       <= low_d;
    cnt_q       <= cnt_d;
    out_lin_q   <= out_lin_d;
    out_ang_q   <= out_ang_d;
    out_inv_q   <= out_inv_d;
    out_phase_q <= out_phase_d;
  end

  // configuration writes, each masked to its register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_step_q    <= LIN_STEP_RST;
      ang_step_q    <= ANG_STEP_RST;
      wait_ticks_q  <= WAIT_TICKS_RST;
      decay_ticks_q <= DECAY_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LIN_STEP:    lin_step_q    <= cfg_wdata_i[STEP_W-1:0];
        CFG_ANG_STEP:    ang_step_q    <= cfg_wdata_i[STEP_W-1:0];
        CFG_WAIT_TICKS:  wait_ticks_q  <= cfg_wdata_i[DUR_W-1:0];
        CFG_DECAY_TICKS: decay_ticks_q <= cfg_wdata_i[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign linear_speed_o    = out_lin_q;
  assign angular_speed_o   = out_ang_q;
  assign invalid_command_o = out_inv_q;
  assign phase_o           = out_phase_q;

endmodule
